/* rtl/mcb_pkg.sv */
// ----------------------------------------------------------------------------
// Center of mass and bounds package
// Shared widths, the sequencer state type and the divider constants.
// ----------------------------------------------------------------------------
package mcb_pkg;

   localparam int unsigned MASS_W   = 20;
   localparam int unsigned POS_W    = 32;
   localparam int unsigned TOTAL_W  = 30;
   localparam int unsigned PROD_W   = MASS_W + 1 + POS_W;
   localparam int unsigned WSUM_W   = 62;
   localparam int unsigned HIGH_W   = 31;
   localparam int unsigned NUM_AXES = 3;
   localparam int unsigned AXIS_W   = 2;

   localparam logic [AXIS_W-1:0] AXIS_FIRST = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_LAST  = 2'd2;

   localparam int unsigned DIV_STEPS = WSUM_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_MUL     = 6'b000010,
      ST_ADD     = 6'b000100,
      ST_DIV_GO  = 6'b001000,
      ST_DIV_RUN = 6'b010000,
      ST_DONE    = 6'b100000
   } state_type;

endpackage

/* rtl/mcb_div.sv */
// ----------------------------------------------------------------------------
// Center of mass serial divider
// Signed 62-bit sum over unsigned 30-bit mass, one quotient bit per cycle,
// truncated toward zero; only the low 32 quotient bits are kept.
// ----------------------------------------------------------------------------
module mcb_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [mcb_pkg::WSUM_W-1:0] dividend,
   input  logic [mcb_pkg::TOTAL_W-1:0]       divisor,
   output logic                              done,
   output logic signed [mcb_pkg::POS_W-1:0]  quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [mcb_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                              neg_ff, neg_in;
   logic [mcb_pkg::WSUM_W-1:0]        mag_ff, mag_in;
   logic [mcb_pkg::TOTAL_W-1:0]       rem_ff, rem_in;
   logic [mcb_pkg::TOTAL_W-1:0]       dvs_ff, dvs_in;
   logic [mcb_pkg::POS_W-1:0]         quot_ff, quot_in;
   logic [mcb_pkg::TOTAL_W:0]         rem_shift;
   logic [mcb_pkg::TOTAL_W:0]         rem_diff;
   logic                              qbit;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      quot_in   = quot_ff;
      rem_shift = {rem_ff, mag_ff[mcb_pkg::WSUM_W-1]};
      rem_diff  = rem_shift - {1'b0, dvs_ff};
      qbit      = (rem_shift >= {1'b0, dvs_ff});
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[mcb_pkg::WSUM_W-1];
         mag_in  = dividend[mcb_pkg::WSUM_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = qbit ? rem_diff[mcb_pkg::TOTAL_W-1:0] : rem_shift[mcb_pkg::TOTAL_W-1:0];
         mag_in  = {mag_ff[mcb_pkg::WSUM_W-2:0], 1'b0};
         quot_in = {quot_ff[mcb_pkg::POS_W-2:0], qbit};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == mcb_pkg::DIV_CNT_W'(mcb_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? $signed(~quot_ff + 1'b1) : $signed(quot_ff);

endmodule

/* rtl/mass_centroid_and_bounds_unit.sv */
// ----------------------------------------------------------------------------
// Mass centroid and bounds unit
// Accumulates total mass, mass-weighted positions and a per-axis box that
// always holds the origin; on the last body of a set it reports the center
// of mass, the box and two flags, then clears.
//
//   channel  direction  handshake            beat
//   req      in         req_valid/req_stall  one body
//   rsp      out        rsp_valid/rsp_stall  one set summary
//
// A body is accepted, then takes a multiply and an add for each axis on one
// shared 21x32 multiplier and one 62-bit adder.
// The last body of a set then runs three passes of the serial divider, one
// per axis, at one quotient bit per cycle over 62 steps each, and then loads
// the output register. With zero total mass only that load is done.
// Reset clears the sums, the box and the body count. The result sits in an
// output register, so a stalled result only holds the next last body.
// ----------------------------------------------------------------------------
module mass_centroid_and_bounds_unit #(
   parameter int unsigned MAX_BODIES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mcb_pkg::MASS_W-1:0]        req_body_mass,
   input  logic signed [mcb_pkg::POS_W-1:0]  req_pos_x1,
   input  logic signed [mcb_pkg::POS_W-1:0]  req_pos_x2,
   input  logic signed [mcb_pkg::POS_W-1:0]  req_pos_x3,
   input  logic                              req_last_body,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mcb_pkg::TOTAL_W-1:0]       rsp_total_mass,
   output logic signed [mcb_pkg::POS_W-1:0]  rsp_centre_x1,
   output logic signed [mcb_pkg::POS_W-1:0]  rsp_centre_x2,
   output logic signed [mcb_pkg::POS_W-1:0]  rsp_centre_x3,
   output logic signed [mcb_pkg::POS_W-1:0]  rsp_low_x1,
   output logic [mcb_pkg::HIGH_W-1:0]        rsp_high_x1,
   output logic signed [mcb_pkg::POS_W-1:0]  rsp_low_x2,
   output logic [mcb_pkg::HIGH_W-1:0]        rsp_high_x2,
   output logic signed [mcb_pkg::POS_W-1:0]  rsp_low_x3,
   output logic [mcb_pkg::HIGH_W-1:0]        rsp_high_x3,
   output logic                              rsp_zero_mass,
   output logic                              rsp_too_many_bodies
);

   localparam int unsigned CNT_W = $clog2(MAX_BODIES + 2);
   localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(MAX_BODIES + 1);
   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_BODIES);
   localparam int unsigned NA = mcb_pkg::NUM_AXES;

   mcb_pkg::state_type                 state_ff, state_in;
   logic [mcb_pkg::AXIS_W-1:0]         axis_ff, axis_in;
   logic [mcb_pkg::MASS_W-1:0]         mass_ff, mass_in;
   logic signed [mcb_pkg::POS_W-1:0]   pos_ff [NA];
   logic signed [mcb_pkg::POS_W-1:0]   pos_in [NA];
   logic                               last_ff, last_in;
   logic signed [mcb_pkg::PROD_W-1:0]  prod_ff, prod_in;

   logic [mcb_pkg::TOTAL_W-1:0]        msum_ff, msum_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic signed [mcb_pkg::WSUM_W-1:0]  wsum_ff [NA];
   logic signed [mcb_pkg::WSUM_W-1:0]  wsum_in [NA];
   logic signed [mcb_pkg::POS_W-1:0]   low_ff [NA];
   logic signed [mcb_pkg::POS_W-1:0]   low_in [NA];
   logic [mcb_pkg::HIGH_W-1:0]         high_ff [NA];
   logic [mcb_pkg::HIGH_W-1:0]         high_in [NA];
   logic signed [mcb_pkg::POS_W-1:0]   centre_ff [NA];
   logic signed [mcb_pkg::POS_W-1:0]   centre_in [NA];

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [mcb_pkg::TOTAL_W-1:0]        out_mass_ff, out_mass_in;
   logic signed [mcb_pkg::POS_W-1:0]   out_centre_ff [NA];
   logic signed [mcb_pkg::POS_W-1:0]   out_centre_in [NA];
   logic signed [mcb_pkg::POS_W-1:0]   out_low_ff [NA];
   logic signed [mcb_pkg::POS_W-1:0]   out_low_in [NA];
   logic [mcb_pkg::HIGH_W-1:0]         out_high_ff [NA];
   logic [mcb_pkg::HIGH_W-1:0]         out_high_in [NA];
   logic                               out_zero_ff, out_zero_in;
   logic                               out_over_ff, out_over_in;

   logic                               div_start;
   logic                               div_done;
   logic signed [mcb_pkg::POS_W-1:0]   div_quot;
   logic signed [mcb_pkg::POS_W-1:0]   req_pos [NA];
   logic                               req_take;

   assign req_pos[0] = req_pos_x1;
   assign req_pos[1] = req_pos_x2;
   assign req_pos[2] = req_pos_x3;
   assign req_take   = req_valid && (state_ff == mcb_pkg::ST_IDLE);

   mcb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (wsum_ff[axis_ff]),
      .divisor  (msum_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      mass_in      = mass_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      msum_in      = msum_ff;
      count_in     = count_ff;
      wsum_in      = wsum_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      centre_in    = centre_ff;
      rsp_valid_in = rsp_valid_ff;
      out_mass_in  = out_mass_ff;
      out_centre_in = out_centre_ff;
      out_low_in   = out_low_ff;
      out_high_in  = out_high_ff;
      out_zero_in  = out_zero_ff;
      out_over_in  = out_over_ff;
      div_start    = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         mcb_pkg::ST_IDLE: begin
            if (req_valid) begin
               mass_in  = req_body_mass;
               pos_in   = req_pos;
               last_in  = req_last_body;
               msum_in  = msum_ff + mcb_pkg::TOTAL_W'(req_body_mass);
               if (count_ff != COUNT_CAP) begin
                  count_in = count_ff + 1'b1;
               end
               for (int a = 0; a < NA; a++) begin
                  if (req_pos[a] < low_ff[a]) begin
                     low_in[a] = req_pos[a];
                  end else if (!req_pos[a][mcb_pkg::POS_W-1] &&
                               (req_pos[a][mcb_pkg::HIGH_W-1:0] > high_ff[a])) begin
                     high_in[a] = req_pos[a][mcb_pkg::HIGH_W-1:0];
                  end
               end
               axis_in  = mcb_pkg::AXIS_FIRST;
               state_in = mcb_pkg::ST_MUL;
            end
         end
         mcb_pkg::ST_MUL: begin
            prod_in  = $signed({1'b0, mass_ff}) * pos_ff[axis_ff];
            state_in = mcb_pkg::ST_ADD;
         end
         mcb_pkg::ST_ADD: begin
            wsum_in[axis_ff] = wsum_ff[axis_ff] +
               {{(mcb_pkg::WSUM_W - mcb_pkg::PROD_W){prod_ff[mcb_pkg::PROD_W-1]}}, prod_ff};
            if (axis_ff != mcb_pkg::AXIS_LAST) begin
               axis_in  = axis_ff + 1'b1;
               state_in = mcb_pkg::ST_MUL;
            end else if (!last_ff) begin
               state_in = mcb_pkg::ST_IDLE;
            end else if (msum_ff == '0) begin
               for (int a = 0; a < NA; a++) begin
                  centre_in[a] = '0;
               end
               state_in = mcb_pkg::ST_DONE;
            end else begin
               axis_in  = mcb_pkg::AXIS_FIRST;
               state_in = mcb_pkg::ST_DIV_GO;
            end
         end
         mcb_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = mcb_pkg::ST_DIV_RUN;
         end
         mcb_pkg::ST_DIV_RUN: begin
            if (div_done) begin
               centre_in[axis_ff] = div_quot;
               if (axis_ff != mcb_pkg::AXIS_LAST) begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = mcb_pkg::ST_DIV_GO;
               end else begin
                  state_in = mcb_pkg::ST_DONE;
               end
            end
         end
         mcb_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               out_mass_in   = msum_ff;
               out_centre_in = centre_ff;
               out_low_in    = low_ff;
               out_high_in   = high_ff;
               out_zero_in   = (msum_ff == '0);
               out_over_in   = (count_ff > COUNT_MAX);
               msum_in       = '0;
               count_in      = '0;
               for (int a = 0; a < NA; a++) begin
                  wsum_in[a] = '0;
                  low_in[a]  = '0;
                  high_in[a] = '0;
               end
               state_in = mcb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mcb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         msum_ff      <= '0;
         count_ff     <= '0;
         for (int a = 0; a < NA; a++) begin
            wsum_ff[a] <= '0;
            low_ff[a]  <= '0;
            high_ff[a] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         msum_ff      <= msum_in;
         count_ff     <= count_in;
         wsum_ff      <= wsum_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
      end
      axis_ff       <= axis_in;
      mass_ff       <= mass_in;
      pos_ff        <= pos_in;
      last_ff       <= last_in;
      prod_ff       <= prod_in;
      centre_ff     <= centre_in;
      out_mass_ff   <= out_mass_in;
      out_centre_ff <= out_centre_in;
      out_low_ff    <= out_low_in;
      out_high_ff   <= out_high_in;
      out_zero_ff   <= out_zero_in;
      out_over_ff   <= out_over_in;
   end

   assign req_stall           = !req_take && (state_ff != mcb_pkg::ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_total_mass      = out_mass_ff;
   assign rsp_centre_x1       = out_centre_ff[0];
   assign rsp_centre_x2       = out_centre_ff[1];
   assign rsp_centre_x3       = out_centre_ff[2];
   assign rsp_low_x1          = out_low_ff[0];
   assign rsp_high_x1         = out_high_ff[0];
   assign rsp_low_x2          = out_low_ff[1];
   assign rsp_high_x2         = out_high_ff[1];
   assign rsp_low_x3          = out_low_ff[2];
   assign rsp_high_x3         = out_high_ff[2];
   assign rsp_zero_mass       = out_zero_ff;
   assign rsp_too_many_bodies = out_over_ff;

endmodule

/* dv/mcb_summary_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set summary checker for the mass centroid and bounds unit
// Watches both channels. Each accepted body updates a local copy of the mass
// sum, the weighted position sums, the box and the body count. A last body
// queues the summary that the unit owes. Every accepted summary is compared
// field by field with the oldest one owed.
// ----------------------------------------------------------------------------
module mcb_summary_checker #(
   parameter int unsigned MAX_BODIES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [mcb_pkg::MASS_W-1:0]        req_body_mass,
   input  logic signed [mcb_pkg::POS_W-1:0]  req_pos_x1,
   input  logic signed [mcb_pkg::POS_W-1:0]  req_pos_x2,
   input  logic signed [mcb_pkg::POS_W-1:0]  req_pos_x3,
   input  logic                              req_last_body,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [mcb_pkg::TOTAL_W-1:0]       rsp_total_mass,
   input  logic signed [mcb_pkg::POS_W-1:0]  rsp_centre_x1,
   input  logic signed [mcb_pkg::POS_W-1:0]  rsp_centre_x2,
   input  logic signed [mcb_pkg::POS_W-1:0]  rsp_centre_x3,
   input  logic signed [mcb_pkg::POS_W-1:0]  rsp_low_x1,
   input  logic [mcb_pkg::HIGH_W-1:0]        rsp_high_x1,
   input  logic signed [mcb_pkg::POS_W-1:0]  rsp_low_x2,
   input  logic [mcb_pkg::HIGH_W-1:0]        rsp_high_x2,
   input  logic signed [mcb_pkg::POS_W-1:0]  rsp_low_x3,
   input  logic [mcb_pkg::HIGH_W-1:0]        rsp_high_x3,
   input  logic                              rsp_zero_mass,
   input  logic                              rsp_too_many_bodies,
   output int                                due_count,
   output int                                mismatch_count
);

   typedef struct packed {
      logic [mcb_pkg::TOTAL_W-1:0]                         total;
      logic [mcb_pkg::NUM_AXES-1:0][mcb_pkg::POS_W-1:0]    centre;
      logic [mcb_pkg::NUM_AXES-1:0][mcb_pkg::POS_W-1:0]    low;
      logic [mcb_pkg::NUM_AXES-1:0][mcb_pkg::HIGH_W-1:0]   high;
      logic                                                zero_mass;
      logic                                                too_many;
   } set_summary_type;

   logic [mcb_pkg::TOTAL_W-1:0]        mass_total;
   logic [mcb_pkg::WSUM_W-1:0]         moment [mcb_pkg::NUM_AXES];
   logic signed [mcb_pkg::POS_W-1:0]   box_low [mcb_pkg::NUM_AXES];
   logic signed [mcb_pkg::POS_W-1:0]   box_high [mcb_pkg::NUM_AXES];
   int unsigned                        bodies_seen;
   set_summary_type                    due_summaries [$];

   task automatic clear_sums();
      mass_total = '0;
      bodies_seen = 0;
      for (int a = 0; a < mcb_pkg::NUM_AXES; a++) begin
         moment[a] = '0;
         box_low[a] = '0;
         box_high[a] = '0;
      end
   endtask

   task automatic compare_field(input string name, input logic [mcb_pkg::POS_W-1:0] want,
                                input logic [mcb_pkg::POS_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      logic signed [mcb_pkg::POS_W-1:0]                    p;
      logic [mcb_pkg::NUM_AXES-1:0][mcb_pkg::POS_W-1:0]    pos;
      logic [mcb_pkg::NUM_AXES-1:0][mcb_pkg::POS_W-1:0]    got_centre;
      logic [mcb_pkg::NUM_AXES-1:0][mcb_pkg::POS_W-1:0]    got_low;
      logic [mcb_pkg::NUM_AXES-1:0][mcb_pkg::HIGH_W-1:0]   got_high;
      longint                                              prod;
      longint                                              num;
      longint                                              quo;
      set_summary_type                                     s;

      if (reset) begin
         clear_sums();
         due_summaries.delete();
      end else begin
         if (req_valid && !req_stall) begin
            pos = {req_pos_x3, req_pos_x2, req_pos_x1};
            mass_total = mass_total + mcb_pkg::TOTAL_W'(req_body_mass);
            if (bodies_seen <= MAX_BODIES) begin
               bodies_seen++;
            end
            for (int a = 0; a < mcb_pkg::NUM_AXES; a++) begin
               p = signed'(pos[a]);
               prod = longint'(req_body_mass) * longint'(p);
               moment[a] = moment[a] + prod[mcb_pkg::WSUM_W-1:0];
               if (p < box_low[a]) begin
                  box_low[a] = p;
               end else if (p > box_high[a]) begin
                  box_high[a] = p;
               end
            end
            if (req_last_body) begin
               s.total = mass_total;
               for (int a = 0; a < mcb_pkg::NUM_AXES; a++) begin
                  if (mass_total != 0) begin
                     num = longint'(signed'(moment[a]));
                     quo = num / longint'(mass_total);
                     s.centre[a] = quo[mcb_pkg::POS_W-1:0];
                  end else begin
                     s.centre[a] = '0;
                  end
                  s.low[a] = box_low[a];
                  s.high[a] = box_high[a][mcb_pkg::HIGH_W-1:0];
               end
               s.zero_mass = (mass_total == 0);
               s.too_many = (bodies_seen > MAX_BODIES);
               due_summaries.push_back(s);
               clear_sums();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_summaries.size() == 0) begin
               mismatch_count++;
               $display("%0t: summary beat with none owed, expected none, actual total %h",
                        $time, rsp_total_mass);
            end else begin
               s = due_summaries.pop_front();
               got_centre = {rsp_centre_x3, rsp_centre_x2, rsp_centre_x1};
               got_low = {rsp_low_x3, rsp_low_x2, rsp_low_x1};
               got_high = {rsp_high_x3, rsp_high_x2, rsp_high_x1};
               compare_field("total_mass", mcb_pkg::POS_W'(s.total),
                             mcb_pkg::POS_W'(rsp_total_mass));
               for (int a = 0; a < mcb_pkg::NUM_AXES; a++) begin
                  compare_field($sformatf("centre_x%0d", a + 1), s.centre[a], got_centre[a]);
                  compare_field($sformatf("low_x%0d", a + 1), s.low[a], got_low[a]);
                  compare_field($sformatf("high_x%0d", a + 1), mcb_pkg::POS_W'(s.high[a]),
                                mcb_pkg::POS_W'(got_high[a]));
               end
               compare_field("zero_mass", mcb_pkg::POS_W'(s.zero_mass),
                             mcb_pkg::POS_W'(rsp_zero_mass));
               compare_field("too_many_bodies", mcb_pkg::POS_W'(s.too_many),
                             mcb_pkg::POS_W'(rsp_too_many_bodies));
            end
         end
      end
      due_count = due_summaries.size();
   end

endmodule

/* dv/tb_mass_centroid_and_bounds_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the mass centroid and bounds unit
// Sends directed bodies, one set past the body count limit and random sets of
// random size and content, first while both sides stall at random and then
// with no stalls, and leaves all checking to the summary checker.
// ----------------------------------------------------------------------------
module tb_mass_centroid_and_bounds_unit;

   localparam int unsigned MAX_BODIES = 1024;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [mcb_pkg::MASS_W-1:0]        req_body_mass;
   logic signed [mcb_pkg::POS_W-1:0]  req_pos_x1;
   logic signed [mcb_pkg::POS_W-1:0]  req_pos_x2;
   logic signed [mcb_pkg::POS_W-1:0]  req_pos_x3;
   logic                              req_last_body;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [mcb_pkg::TOTAL_W-1:0]       rsp_total_mass;
   logic signed [mcb_pkg::POS_W-1:0]  rsp_centre_x1;
   logic signed [mcb_pkg::POS_W-1:0]  rsp_centre_x2;
   logic signed [mcb_pkg::POS_W-1:0]  rsp_centre_x3;
   logic signed [mcb_pkg::POS_W-1:0]  rsp_low_x1;
   logic [mcb_pkg::HIGH_W-1:0]        rsp_high_x1;
   logic signed [mcb_pkg::POS_W-1:0]  rsp_low_x2;
   logic [mcb_pkg::HIGH_W-1:0]        rsp_high_x2;
   logic signed [mcb_pkg::POS_W-1:0]  rsp_low_x3;
   logic [mcb_pkg::HIGH_W-1:0]        rsp_high_x3;
   logic                              rsp_zero_mass;
   logic                              rsp_too_many_bodies;
   int                                due_count;
   int                                mismatch_count;
   int                                send_idle;
   int                                recv_idle;

   mass_centroid_and_bounds_unit #(.MAX_BODIES(MAX_BODIES)) i_dut (.*);

   mcb_summary_checker #(.MAX_BODIES(MAX_BODIES)) i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   initial begin
      #60_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic logic [mcb_pkg::MASS_W-1:0] rand_mass();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return mcb_pkg::MASS_W'($urandom_range(15));
         default: return mcb_pkg::MASS_W'($urandom);
      endcase
   endfunction

   function automatic logic [mcb_pkg::POS_W-1:0] rand_pos();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return $urandom_range(8) - 4;
         4: return $urandom << 16;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_body(input logic [mcb_pkg::MASS_W-1:0] m,
                            input logic [mcb_pkg::POS_W-1:0] x1,
                            input logic [mcb_pkg::POS_W-1:0] x2,
                            input logic [mcb_pkg::POS_W-1:0] x3,
                            input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_body_mass <= m;
      req_pos_x1 <= x1;
      req_pos_x2 <= x2;
      req_pos_x3 <= x3;
      req_last_body <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_set(input int unsigned n, input logic heavy);
      for (int unsigned i = 0; i < n; i++) begin
         send_body(heavy ? '1 : rand_mass(), rand_pos(), rand_pos(), rand_pos(), i == n - 1);
      end
   endtask

   task automatic send_random_sets(input int unsigned n_bodies);
      int unsigned sent;
      int unsigned n;
      sent = 0;
      while (sent < n_bodies) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
         send_set(n, 1'b0);
         sent += n;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (due_count != 0) @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_body_mass = '0;
      req_pos_x1 = '0;
      req_pos_x2 = '0;
      req_pos_x3 = '0;
      req_last_body = 1'b0;
      send_idle = 33;
      recv_idle = 45;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_body('0, '0, '0, '0, 1'b1);
      send_body('1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b1);
      send_body('0, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 1'b0);
      send_body('0, 1, -1, '0, 1'b1);
      send_body(20'd1, -5, 5, -7, 1'b0);
      send_body(20'd1, '0, '0, '0, 1'b1);
      send_body(20'd3, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
      send_body('1, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_body(20'd2, 32'h7fff_fffe, 32'h8000_0001, 32'h0000_8000, 1'b1);
      send_body(20'd7, 32'h0003_0000, 32'h0000_0001, 32'h1234_5678, 1'b0);
      send_body(20'd9, 32'h0001_8000, 32'h0000_0002, 32'h0000_0010, 1'b1);
      send_body(20'd5, -32'sh3_0000, -1, -32'sh1234_5678, 1'b0);
      send_body(20'd11, -32'sh1_8000, -2, -16, 1'b1);
      send_body(20'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
      send_body(20'h8_0000, 32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 1'b1);
      send_random_sets(200);
      drain();

      send_idle = 45;
      recv_idle = 33;
      send_set(MAX_BODIES + 1, 1'b1);
      send_random_sets(150);
      drain();

      send_idle = 0;
      recv_idle = 0;
      send_random_sets(260);
      drain();

      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && due_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/mcb_pkg.sv
rtl/mcb_div.sv
rtl/mass_centroid_and_bounds_unit.sv
dv/mcb_summary_checker.sv
dv/tb_mass_centroid_and_bounds_unit.sv
